@@ rtl/gtls_pkg.sv @@
// Shared types and constants for the gimbal track/lost/search controller.
// No dependencies; imported by every module of the block.
package gtls_pkg;

   localparam int COUNT_WIDTH_DEF = 11;

   localparam int ANGLE_WIDTH = 15;
   localparam int DIST_WIDTH  = 16;
   localparam int GAIN_WIDTH  = 16;
   localparam int MAG_WIDTH   = 14;
   localparam int THR_WIDTH   = 10;
   localparam int MISS_WIDTH  = 11;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   localparam int REQ_TDATA_WIDTH = 48;
   localparam int REQ_TUSER_WIDTH = 2;
   localparam int RSP_TDATA_WIDTH = 64;
   localparam int RSP_TUSER_WIDTH = 2;

   // result tdata layout
   localparam int RSP_CTRL_BIT   = 0;
   localparam int RSP_YAW_LSB    = 1;
   localparam int RSP_PITCH_LSB  = 16;
   localparam int RSP_DIST_LSB   = 31;
   localparam int RSP_FIRE_BIT   = 47;
   localparam int RSP_MISS_LSB   = 48;

   // Q4.12 gain scaling and x/5 by reciprocal: floor(x*52429 / 2^18)
   localparam int              GAIN_SHIFT = 12;
   localparam int              DIV5_SHIFT = 18;
   localparam logic [GAIN_WIDTH-1:0] DIV5_RECIP = 16'd52429;

   typedef enum logic [2:0] {
      CSR_YAW_GAIN    = 3'd0,
      CSR_PITCH_GAIN  = 3'd1,
      CSR_MAX_COMMAND = 3'd2,
      CSR_FIRE_YAW    = 3'd3,
      CSR_FIRE_PITCH  = 3'd4,
      CSR_LOST_THR    = 3'd5,
      CSR_SEARCH_THR  = 3'd6,
      CSR_SEARCH_YAW  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_TRACK  = 2'd1,
      MODE_LOST   = 2'd2,
      MODE_SEARCH = 2'd3
   } mode_type;

   typedef struct packed {
      logic [GAIN_WIDTH-1:0] yaw_gain;
      logic [GAIN_WIDTH-1:0] pitch_gain;
      logic [MAG_WIDTH-1:0]  max_command;
      logic [MAG_WIDTH-1:0]  fire_yaw_tolerance;
      logic [MAG_WIDTH-1:0]  fire_pitch_tolerance;
      logic [THR_WIDTH-1:0]  lost_threshold;
      logic [THR_WIDTH-1:0]  search_threshold;
      logic [MAG_WIDTH-1:0]  search_yaw;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic miss_upd;
      logic calc;
      logic div_step;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic frame;
      logic search;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

@@ rtl/gtls_csr.sv @@
// Configuration register file on an APB-style port.
// Depends on gtls_pkg for the register map and the cfg_type bundle.
module gtls_csr import gtls_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output cfg_type                   cfg
);

   cfg_type       cfg_ff, cfg_in;
   csr_index_type idx;
   logic          wr;

   assign idx = csr_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign wr  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            CSR_YAW_GAIN:    cfg_in.yaw_gain             = csr_pwdata[GAIN_WIDTH-1:0];
            CSR_PITCH_GAIN:  cfg_in.pitch_gain           = csr_pwdata[GAIN_WIDTH-1:0];
            CSR_MAX_COMMAND: cfg_in.max_command          = csr_pwdata[MAG_WIDTH-1:0];
            CSR_FIRE_YAW:    cfg_in.fire_yaw_tolerance   = csr_pwdata[MAG_WIDTH-1:0];
            CSR_FIRE_PITCH:  cfg_in.fire_pitch_tolerance = csr_pwdata[MAG_WIDTH-1:0];
            CSR_LOST_THR:    cfg_in.lost_threshold       = csr_pwdata[THR_WIDTH-1:0];
            CSR_SEARCH_THR:  cfg_in.search_threshold     = csr_pwdata[THR_WIDTH-1:0];
            CSR_SEARCH_YAW:  cfg_in.search_yaw           = csr_pwdata[MAG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.yaw_gain             <= 16'd4096;
         cfg_ff.pitch_gain           <= 16'd4096;
         cfg_ff.max_command          <= 14'd640;
         cfg_ff.fire_yaw_tolerance   <= 14'd64;
         cfg_ff.fire_pitch_tolerance <= 14'd64;
         cfg_ff.lost_threshold       <= 10'd10;
         cfg_ff.search_threshold     <= 10'd60;
         cfg_ff.search_yaw           <= 14'd320;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         CSR_YAW_GAIN:    csr_prdata = CSR_DATA_WIDTH'(cfg_ff.yaw_gain);
         CSR_PITCH_GAIN:  csr_prdata = CSR_DATA_WIDTH'(cfg_ff.pitch_gain);
         CSR_MAX_COMMAND: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.max_command);
         CSR_FIRE_YAW:    csr_prdata = CSR_DATA_WIDTH'(cfg_ff.fire_yaw_tolerance);
         CSR_FIRE_PITCH:  csr_prdata = CSR_DATA_WIDTH'(cfg_ff.fire_pitch_tolerance);
         CSR_LOST_THR:    csr_prdata = CSR_DATA_WIDTH'(cfg_ff.lost_threshold);
         CSR_SEARCH_THR:  csr_prdata = CSR_DATA_WIDTH'(cfg_ff.search_threshold);
         CSR_SEARCH_YAW:  csr_prdata = CSR_DATA_WIDTH'(cfg_ff.search_yaw);
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/gtls_ctrl.sv @@
// Sequencer for one frame event: accept, miss update, multiply, divide, load.
// Depends on gtls_pkg for the command and status bundles.
module gtls_ctrl import gtls_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MISS = 5'b00010,
      ST_CALC = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_LOAD = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) state_in = ST_MISS;
         end
         ST_MISS: begin
            cmd.miss_upd = 1'b1;
            state_in     = status.frame ? ST_CALC : ST_IDLE;
         end
         ST_CALC: begin
            // also seeds the divider; only a sweep needs its quotient
            cmd.calc = 1'b1;
            state_in = status.search ? ST_DIV : ST_LOAD;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ rtl/gtls_dp.sv @@
// Datapath: input capture, miss counter and mode, gain/decay multipliers,
// restoring divider for the sweep parity, held command and result register.
// Depends on gtls_pkg.
module gtls_dp import gtls_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  logic [REQ_TUSER_WIDTH-1:0] req_tuser,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   output logic [RSP_TUSER_WIDTH-1:0] rsp_tuser
);

   localparam int CMP_WIDTH  = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH + 1;
   localparam int STEP_WIDTH = $clog2(COUNT_WIDTH + 1);
   localparam int OPA_WIDTH  = ANGLE_WIDTH + 2;
   localparam int PROD_WIDTH = OPA_WIDTH + GAIN_WIDTH;
   localparam int TRK_WIDTH  = PROD_WIDTH - GAIN_SHIFT;

   // captured beat
   logic                   kind_ff, found_ff;
   logic [ANGLE_WIDTH-1:0] ty_ff, tp_ff;
   logic [DIST_WIDTH-1:0]  td_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_tuser[0];
         found_ff <= req_tuser[1];
         ty_ff    <= req_tdata[ANGLE_WIDTH-1:0];
         tp_ff    <= req_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH];
         td_ff    <= req_tdata[2*ANGLE_WIDTH+DIST_WIDTH-1:2*ANGLE_WIDTH];
      end
   end

   logic track;
   assign track = kind_ff & found_ff;

   // miss counter and mode
   logic [COUNT_WIDTH-1:0] miss_ff, miss_in, miss_inc;
   logic [CMP_WIDTH-1:0]   lost_ext, search_ext, inc_ext;
   mode_type               mode_ff, mode_in;

   assign miss_inc   = miss_ff + 1'b1;
   assign inc_ext    = CMP_WIDTH'(miss_inc);
   assign lost_ext   = CMP_WIDTH'(cfg.lost_threshold);
   assign search_ext = CMP_WIDTH'(cfg.search_threshold);

   always_comb begin
      miss_in = miss_ff;
      mode_in = mode_ff;
      if (cmd.miss_upd) begin
         if (track) begin
            miss_in = '0;
            mode_in = MODE_TRACK;
         end else if (inc_ext <= lost_ext) begin
            miss_in = miss_inc;
            mode_in = MODE_LOST;
         end else if (inc_ext <= search_ext) begin
            miss_in = miss_inc;
            mode_in = MODE_SEARCH;
         end else begin
            miss_in = COUNT_WIDTH'(lost_ext + 1'b1);
            mode_in = MODE_SEARCH;
         end
      end
   end

   // held command
   logic                   held_ctrl_ff, held_ctrl_in;
   logic [ANGLE_WIDTH-1:0] held_yaw_ff, held_yaw_in, held_pitch_ff, held_pitch_in;
   logic [DIST_WIDTH-1:0]  held_dist_ff, held_dist_in;
   logic                   held_fire_ff, held_fire_in;

   // magnitudes
   logic [ANGLE_WIDTH-1:0] mag_ty, mag_tp, mag_hy, mag_hp;
   assign mag_ty = ty_ff[ANGLE_WIDTH-1] ? (~ty_ff + 1'b1) : ty_ff;
   assign mag_tp = tp_ff[ANGLE_WIDTH-1] ? (~tp_ff + 1'b1) : tp_ff;
   assign mag_hy = held_yaw_ff[ANGLE_WIDTH-1] ? (~held_yaw_ff + 1'b1) : held_yaw_ff;
   assign mag_hp = held_pitch_ff[ANGLE_WIDTH-1] ? (~held_pitch_ff + 1'b1) : held_pitch_ff;

   // shared multipliers: gain product when tracking, 4*v*recip(5) when decaying
   logic [OPA_WIDTH-1:0]  opa_y, opa_p;
   logic [GAIN_WIDTH-1:0] opb_y, opb_p;
   logic [PROD_WIDTH-1:0] prod_y_ff, prod_p_ff;

   assign opa_y = track ? {2'b00, mag_ty} : {mag_hy, 2'b00};
   assign opa_p = track ? {2'b00, mag_tp} : {mag_hp, 2'b00};
   assign opb_y = track ? cfg.yaw_gain   : DIV5_RECIP;
   assign opb_p = track ? cfg.pitch_gain : DIV5_RECIP;

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         prod_y_ff <= PROD_WIDTH'(opa_y) * PROD_WIDTH'(opb_y);
         prod_p_ff <= PROD_WIDTH'(opa_p) * PROD_WIDTH'(opb_p);
      end
   end

   // restoring divider, one quotient bit per step; only the last bit is kept
   logic [THR_WIDTH-1:0]   divisor, rem_ff, rem_next;
   logic [THR_WIDTH:0]     trial;
   logic                   q_bit, qbit_ff;
   logic [COUNT_WIDTH-1:0] dvd_ff;
   logic [STEP_WIDTH-1:0]  step_ff;

   assign divisor  = (cfg.search_threshold == '0) ? THR_WIDTH'(1) : cfg.search_threshold;
   assign trial    = {rem_ff, dvd_ff[COUNT_WIDTH-1]};
   assign q_bit    = (trial >= {1'b0, divisor});
   assign rem_next = q_bit ? THR_WIDTH'(trial - {1'b0, divisor}) : trial[THR_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         rem_ff <= '0;
         dvd_ff <= miss_ff;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_next;
         dvd_ff  <= dvd_ff << 1;
         qbit_ff <= q_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)             step_ff <= '0;
      else if (cmd.calc)     step_ff <= STEP_WIDTH'(COUNT_WIDTH);
      else if (cmd.div_step) step_ff <= step_ff - 1'b1;
   end

   // command forming
   logic [TRK_WIDTH-1:0]   trk_y_raw, trk_p_raw;
   logic [MAG_WIDTH-1:0]   trk_y_mag, trk_p_mag;
   logic [ANGLE_WIDTH-1:0] trk_y_ext, trk_p_ext, trk_yaw, trk_pitch;
   logic [ANGLE_WIDTH-1:0] dec_y_mag, dec_p_mag, dec_yaw, dec_pitch;
   logic [ANGLE_WIDTH-1:0] sweep_ext, sweep_yaw;
   logic                   fire_ok;

   assign trk_y_raw = prod_y_ff[PROD_WIDTH-1:GAIN_SHIFT];
   assign trk_p_raw = prod_p_ff[PROD_WIDTH-1:GAIN_SHIFT];
   assign trk_y_mag = (trk_y_raw > TRK_WIDTH'(cfg.max_command)) ? cfg.max_command
                                                               : trk_y_raw[MAG_WIDTH-1:0];
   assign trk_p_mag = (trk_p_raw > TRK_WIDTH'(cfg.max_command)) ? cfg.max_command
                                                               : trk_p_raw[MAG_WIDTH-1:0];
   assign trk_y_ext = {1'b0, trk_y_mag};
   assign trk_p_ext = {1'b0, trk_p_mag};
   // yaw is negated: a non-negative error gives a negative command
   assign trk_yaw   = ty_ff[ANGLE_WIDTH-1] ? trk_y_ext : (~trk_y_ext + 1'b1);
   assign trk_pitch = tp_ff[ANGLE_WIDTH-1] ? (~trk_p_ext + 1'b1) : trk_p_ext;

   assign dec_y_mag = prod_y_ff[DIV5_SHIFT +: ANGLE_WIDTH];
   assign dec_p_mag = prod_p_ff[DIV5_SHIFT +: ANGLE_WIDTH];
   assign dec_yaw   = held_yaw_ff[ANGLE_WIDTH-1]   ? (~dec_y_mag + 1'b1) : dec_y_mag;
   assign dec_pitch = held_pitch_ff[ANGLE_WIDTH-1] ? (~dec_p_mag + 1'b1) : dec_p_mag;

   assign sweep_ext = {1'b0, cfg.search_yaw};
   assign sweep_yaw = qbit_ff ? (~sweep_ext + 1'b1) : sweep_ext;

   assign fire_ok = (mag_ty <= ANGLE_WIDTH'(cfg.fire_yaw_tolerance)) &&
                    (mag_tp <= ANGLE_WIDTH'(cfg.fire_pitch_tolerance));

   always_comb begin
      held_ctrl_in  = held_ctrl_ff;
      held_yaw_in   = held_yaw_ff;
      held_pitch_in = held_pitch_ff;
      held_dist_in  = held_dist_ff;
      held_fire_in  = held_fire_ff;
      if (cmd.load) begin
         case (mode_ff)
            MODE_TRACK: begin
               held_ctrl_in  = 1'b1;
               held_yaw_in   = trk_yaw;
               held_pitch_in = trk_pitch;
               held_dist_in  = td_ff;
               held_fire_in  = fire_ok;
            end
            MODE_LOST: begin
               held_yaw_in   = dec_yaw;
               held_pitch_in = dec_pitch;
               held_fire_in  = 1'b0;
            end
            MODE_SEARCH: begin
               held_ctrl_in  = 1'b1;
               held_yaw_in   = sweep_yaw;
               held_pitch_in = '0;
               held_dist_in  = '0;
               held_fire_in  = 1'b0;
            end
            default: begin
               held_ctrl_in  = 1'b0;
               held_yaw_in   = '0;
               held_pitch_in = '0;
               held_dist_in  = '0;
               held_fire_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         miss_ff       <= '0;
         mode_ff       <= MODE_IDLE;
         held_ctrl_ff  <= 1'b0;
         held_yaw_ff   <= '0;
         held_pitch_ff <= '0;
         held_dist_ff  <= '0;
         held_fire_ff  <= 1'b0;
      end else begin
         miss_ff       <= miss_in;
         mode_ff       <= mode_in;
         held_ctrl_ff  <= held_ctrl_in;
         held_yaw_ff   <= held_yaw_in;
         held_pitch_ff <= held_pitch_in;
         held_dist_ff  <= held_dist_in;
         held_fire_ff  <= held_fire_in;
      end
   end

   // result register
   logic                       rsp_valid_ff;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_ff;
   logic [RSP_TUSER_WIDTH-1:0] rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset)           rsp_valid_ff <= 1'b0;
      else if (cmd.load)   rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data_ff <= {5'b00000, MISS_WIDTH'(miss_ff), held_fire_in, held_dist_in,
                         held_pitch_in, held_yaw_in, held_ctrl_in};
         rsp_user_ff <= mode_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign status.frame    = kind_ff;
   assign status.search   = (mode_ff == MODE_SEARCH);
   assign status.div_done = (step_ff == STEP_WIDTH'(1));
   assign status.out_free = ~rsp_valid_ff | rsp_tready;

endmodule

@@ rtl/gimbal_track_lost_search_control.sv @@
// Gimbal track/lost/search controller, top level.
// Depends on gtls_pkg, gtls_csr, gtls_ctrl and gtls_dp.
//
// One req_ beat is one frame event; tuser says whether an image came and
// whether a target was solved. An event without an image only updates the
// miss counter and mode and yields no rsp_ beat; every frame yields exactly one beat.
// A tracking or lost frame passes through capture, miss update, multiply
// and load; a search frame also runs a divide step, where the sweep direction
// comes from a restoring divider that produces one quotient bit per cycle.
// A no-image event frees the input after its miss update. One event at a time.
// The result sits in an output register; while the receiver stalls a new
// event may be accepted and worked on, and it waits in its load step until
// that register is taken.
// Reset (synchronous) restores the register defaults, mode idle, a zero miss
// count and a zero held command. The user must write the csr_ port only
// while idle; the block itself does not enforce this. pready is always high.
module gimbal_track_lost_search_control import gtls_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [14:0] target_yaw, [29:15] target_pitch, [45:30] target_distance, [47:46] zero
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // [0] kind, [1] has_target
   input  logic [REQ_TUSER_WIDTH-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [0] control_on, [15:1] yaw_command, [30:16] pitch_command,
   // [46:31] distance_out, [47] fire, [58:48] missed_count, [63:59] zero
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // [1:0] mode
   output logic [RSP_TUSER_WIDTH-1:0] rsp_tuser,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                       csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;

   gtls_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   gtls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gtls_dp #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ rtl/gtls_checker.sv @@
// Port-level checks on the result channel of the controller, bound to the top.
// Depends on gtls_pkg for the mode codes and the result layout.
module gtls_checker import gtls_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input logic [RSP_TUSER_WIDTH-1:0] rsp_tuser
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // tracking beats carry a cleared miss count
   a_track_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == MODE_TRACK |->
         rsp_tdata[RSP_MISS_LSB +: MISS_WIDTH] == '0)
      else $error("tracking beat with nonzero miss count");

   // fire only while tracking; a sweep has control on and zero pitch
   a_fire_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_FIRE_BIT] |-> rsp_tuser == MODE_TRACK)
      else $error("fire outside tracking");

   a_sweep: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == MODE_SEARCH |->
         rsp_tdata[RSP_CTRL_BIT] && rsp_tdata[RSP_PITCH_LSB +: ANGLE_WIDTH] == '0 &&
         rsp_tuser != MODE_IDLE)
      else $error("bad sweep beat");

   a_no_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != MODE_IDLE)
      else $error("result beat in idle mode");

endmodule

bind gimbal_track_lost_search_control gtls_checker u_gtls_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
